/* hw/rtl/w3nlw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WENO3 non-uniform linear weights: shared package
// Widths, defaults and the direction codes.
// ----------------------------------------------------------------------------
package w3nlw_pkg;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int COORD_WIDTH_DEF = 32;

    // Direction codes.
    localparam logic OP_PLUS  = 1'b0;
    localparam logic OP_MINUS = 1'b1;
endpackage

/* hw/rtl/weno3_nonuniform_linear_weights_top.sv */
`timescale 1ns / 1ps
// The divider resolves one quotient bit per pipeline stage.
// Throughput: one item per cycle; busy is always low.
// Reset clears all valid bits; no results appear until items are started.
// The receiver cannot stall: each result shows on o_done for one cycle.
// ----------------------------------------------------------------------------
// WENO3 non-uniform linear weights, top level
// Computes the two linear weights d0 and d1 from five boundary points.
// ----------------------------------------------------------------------------
module weno3_nonuniform_linear_weights_top #(
    parameter int FRAC_BITS   = w3nlw_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = w3nlw_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic signed [COORD_WIDTH-1:0] i_x_left2,
    input  logic signed [COORD_WIDTH-1:0] i_x_left1,
    input  logic signed [COORD_WIDTH-1:0] i_x_mid,
    input  logic signed [COORD_WIDTH-1:0] i_x_right1,
    input  logic signed [COORD_WIDTH-1:0] i_x_right2,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_weight_zero,
    output logic signed [COORD_WIDTH-1:0] o_weight_one,
    output logic                          o_error_flag
);
    import w3nlw_pkg::*;

    logic                          f_valid, f_degen;
    logic signed [COORD_WIDTH+2:0] f_num0, f_num1, f_total;
    logic [COORD_WIDTH-1:0]        q0, q1;

    // The pipeline never stalls.
    assign busy = 1'b0;

    w3nlw_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid (start && !busy),
        .i_op,
        .i_p0    (i_x_left2),
        .i_p1    (i_x_left1),
        .i_p2    (i_x_mid),
        .i_p3    (i_x_right1),
        .i_p4    (i_x_right2),
        .o_valid (f_valid),
        .o_num0  (f_num0),
        .o_num1  (f_num1),
        .o_total (f_total),
        .o_degen (f_degen)
    );

    w3nlw_div #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n,
        .i_valid (f_valid),
        .i_num0  (f_num0),
        .i_num1  (f_num1),
        .i_total (f_total),
        .i_degen (f_degen),
        .o_valid (o_done),
        .o_q0    (q0),
        .o_q1    (q1),
        .o_err   (o_error_flag)
    );

    assign o_weight_zero = q0;
    assign o_weight_one  = q1;
endmodule

/* hw/rtl/w3nlw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WENO3 weights front end
// Forms the widths, numerators and total, and checks for a degenerate stencil.
// Two register stages.
// ----------------------------------------------------------------------------
module w3nlw_front #(
    parameter int CW = w3nlw_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_op,
    input  logic signed [CW-1:0] i_p0,
    input  logic signed [CW-1:0] i_p1,
    input  logic signed [CW-1:0] i_p2,
    input  logic signed [CW-1:0] i_p3,
    input  logic signed [CW-1:0] i_p4,
    output logic                 o_valid,
    output logic signed [CW+2:0] o_num0,
    output logic signed [CW+2:0] o_num1,
    output logic signed [CW+2:0] o_total,
    output logic                 o_degen
);
    import w3nlw_pkg::*;

    logic                 r_v1;
    logic signed [CW:0]   r_w0, r_w1, r_w2;
    logic                 r_op1;
    logic signed [CW:0]   n_w0, n_w1, n_w2;
    logic signed [CW+1:0] s01, s12;
    logic signed [CW+2:0] tot;

    // Stage 1: select the window and take the widths.
    always_comb begin
        if (i_op == OP_PLUS) begin
            n_w0 = (CW+1)'(i_p1) - (CW+1)'(i_p0);
            n_w1 = (CW+1)'(i_p2) - (CW+1)'(i_p1);
            n_w2 = (CW+1)'(i_p3) - (CW+1)'(i_p2);
        end else begin
            n_w0 = (CW+1)'(i_p2) - (CW+1)'(i_p1);
            n_w1 = (CW+1)'(i_p3) - (CW+1)'(i_p2);
            n_w2 = (CW+1)'(i_p4) - (CW+1)'(i_p3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_w0  <= n_w0;
        r_w1  <= n_w1;
        r_w2  <= n_w2;
        r_op1 <= i_op;
    end

    // Stage 2: sums, numerators and the degenerate check.
    assign s01 = (CW+2)'(r_w0) + (CW+2)'(r_w1);
    assign s12 = (CW+2)'(r_w1) + (CW+2)'(r_w2);
    assign tot = (CW+3)'(s01) + (CW+3)'(r_w2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_num0  <= (r_op1 == OP_PLUS) ? (CW+3)'(s01) : (CW+3)'(s12);
        o_num1  <= (r_op1 == OP_PLUS) ? (CW+3)'(r_w2) : (CW+3)'(r_w0);
        o_total <= tot;
        o_degen <= (r_w0 == '0) || (r_w1 == '0) || (r_w2 == '0) ||
                   (s01 == '0) || (s12 == '0) || (tot == '0);
    end
endmodule

/* hw/rtl/w3nlw_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WENO3 weights divider
// Pipelined restoring divider for two quotients sharing one divisor, one
// quotient bit per stage, then rounding, saturation and sign.
// ----------------------------------------------------------------------------
module w3nlw_div #(
    parameter int CW = w3nlw_pkg::COORD_WIDTH_DEF,
    parameter int FB = w3nlw_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW+2:0] i_num0,
    input  logic signed [CW+2:0] i_num1,
    input  logic signed [CW+2:0] i_total,
    input  logic                 i_degen,
    output logic                 o_valid,
    output logic [CW-1:0]        o_q0,
    output logic [CW-1:0]        o_q1,
    output logic                 o_err
);
    import w3nlw_pkg::*;

    // Magnitudes are at most CW+2 bits; dividend shifted by FB+1 fraction bits
    // (one extra for rounding). Quotient bits computed: QB.
    localparam int MW = CW + 2;
    localparam int QB = MW + FB + 1;
    localparam int RW = MW + 1;

    logic              r_v   [QB+1];
    logic [MW-1:0]     r_d   [QB+1];
    logic [MW-1:0]     r_n0  [QB+1];
    logic [MW-1:0]     r_n1  [QB+1];
    logic [RW-1:0]     r_r0  [QB+1];
    logic [RW-1:0]     r_r1  [QB+1];
    logic [QB-1:0]     r_q0  [QB+1];
    logic [QB-1:0]     r_q1  [QB+1];
    logic              r_ng0 [QB+1];
    logic              r_ng1 [QB+1];
    logic              r_dg  [QB+1];

    logic [CW+2:0] a0, a1, ad;

    // Entry: take magnitudes and signs.
    assign a0 = i_num0[CW+2]  ? -i_num0  : i_num0;
    assign a1 = i_num1[CW+2]  ? -i_num1  : i_num1;
    assign ad = i_total[CW+2] ? -i_total : i_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_d[0]   <= MW'(ad);
        r_n0[0]  <= MW'(a0);
        r_n1[0]  <= MW'(a1);
        r_r0[0]  <= '0;
        r_r1[0]  <= '0;
        r_q0[0]  <= '0;
        r_q1[0]  <= '0;
        r_ng0[0] <= i_num0[CW+2] ^ i_total[CW+2];
        r_ng1[0] <= i_num1[CW+2] ^ i_total[CW+2];
        r_dg[0]  <= i_degen;
    end

    // One quotient bit per stage; the dividend bits shift in MSB first,
    // followed by zeros for the fraction.
    for (genvar s = 0; s < QB; s++) begin : g_step
        logic          b0, b1;
        logic [RW:0]   t0, t1;
        logic [RW:0]   dd;
        assign b0 = (s < MW) ? r_n0[s][MW-1-((s < MW) ? s : 0)] : 1'b0;
        assign b1 = (s < MW) ? r_n1[s][MW-1-((s < MW) ? s : 0)] : 1'b0;
        assign t0 = {r_r0[s], b0};
        assign t1 = {r_r1[s], b1};
        assign dd = (RW+1)'(r_d[s]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_d[s+1]   <= r_d[s];
            r_n0[s+1]  <= r_n0[s];
            r_n1[s+1]  <= r_n1[s];
            r_ng0[s+1] <= r_ng0[s];
            r_ng1[s+1] <= r_ng1[s];
            r_dg[s+1]  <= r_dg[s];
            r_r0[s+1]  <= (t0 >= dd) ? RW'(t0 - dd) : RW'(t0);
            r_r1[s+1]  <= (t1 >= dd) ? RW'(t1 - dd) : RW'(t1);
            r_q0[s+1]  <= {r_q0[s][QB-2:0], t0 >= dd};
            r_q1[s+1]  <= {r_q1[s][QB-2:0], t1 >= dd};
        end
    end

    // Final stage: round half away from zero, saturate, sign, flag degenerate.
    localparam logic [QB-1:0] LIMP = QB'({1'b0, {(CW-1){1'b1}}});
    localparam logic [QB-1:0] LIMN = QB'({1'b1, {(CW-1){1'b0}}});

    logic [QB-1:0] rq0, rq1, l0, l1, m0, m1;
    logic          s0, s1;

    assign rq0 = QB'(r_q0[QB][QB-1:1]) + QB'(r_q0[QB][0]);
    assign rq1 = QB'(r_q1[QB][QB-1:1]) + QB'(r_q1[QB][0]);
    assign l0  = r_ng0[QB] ? LIMN : LIMP;
    assign l1  = r_ng1[QB] ? LIMN : LIMP;
    assign s0  = rq0 > l0;
    assign s1  = rq1 > l1;
    assign m0  = s0 ? l0 : rq0;
    assign m1  = s1 ? l1 : rq1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[QB];
        end
        if (r_dg[QB]) begin
            o_q0  <= CW'(LIMP);
            o_q1  <= CW'(LIMP);
            o_err <= 1'b1;
        end else begin
            o_q0  <= r_ng0[QB] ? CW'(-m0) : CW'(m0);
            o_q1  <= r_ng1[QB] ? CW'(-m1) : CW'(m1);
            o_err <= s0 || s1;
        end
    end
endmodule

/* hw/rtl/w3nlw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WENO3 weights port checker
// Checks port behavior of the top level over time.
// ----------------------------------------------------------------------------
module w3nlw_checker #(
    parameter int FRAC_BITS   = w3nlw_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = w3nlw_pkg::COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_done,
    input logic [COORD_WIDTH-1:0] o_weight_zero,
    input logic [COORD_WIDTH-1:0] o_weight_one,
    input logic                   o_error_flag
);
    // Cycles from an accepted item to its result.
    localparam int LAT = COORD_WIDTH + FRAC_BITS + 7;

    // The block never refuses an item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Nothing comes out directly after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result right after reset");

    // Both weights at the positive limit without error cannot occur.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_weight_zero == {1'b0, {(COORD_WIDTH-1){1'b1}}}) &&
        (o_weight_one == {1'b0, {(COORD_WIDTH-1){1'b1}}}) |-> o_error_flag)
        else $error("double saturation without error");

    // Each result follows an accepted item by exactly the pipeline latency.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("unexpected result");
endmodule

bind weno3_nonuniform_linear_weights_top w3nlw_checker #(
    .FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_chk (.*);
